// File: src/lsaa_pkg.sv
// Shared types and constants for the light sensor auto-ranging averager.
// No dependencies; imported by the top level and the testbench.
`default_nettype none

package lsaa_pkg;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSIZE,
    ST_ADJ,
    ST_READ,
    ST_AVG,
    ST_OUT
  } state_e;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SECONDS  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DARK_OFFSET     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SAT_THRESHOLD   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_SAMPLES   = 3'd4;

  // Register limits and reset values
  localparam logic [8:0]  WS_MIN      = 9'd10;
  localparam logic [8:0]  WS_MAX      = 9'd300;
  localparam logic [8:0]  WS_RESET    = 9'd60;
  localparam logic [15:0] SAT_RESET   = 16'd60000;
  localparam logic [15:0] LOW_RESET   = 16'd750;
  localparam logic [3:0]  RCS_RESET   = 4'd4;

  // Range limits
  localparam logic [1:0]  GAIN_MAX    = 2'd3;
  localparam logic [2:0]  INTEG_MAX   = 3'd5;
  localparam logic [3:0]  RUN_MAX     = 4'd15;
  localparam logic [15:0] REJ_MAX     = 16'hFFFF;

  // window_seconds * 10 fits in 12 bits
  localparam int WS10_W = 12;

  localparam int IN_W  = 32;
  localparam int OUT_W = 104;

  // Result word, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] rejected_count;
    logic [23:0] corrected_visible;
    logic [23:0] rolling_visible;
    logic [9:0]  window_count;
    logic        range_changed;
    logic        night_mode;
    logic [2:0]  integration_index;
    logic [1:0]  gain_index;
    logic        saturated;
    logic [15:0] visible_count;
  } result_t;

endpackage

`default_nettype wire

// File: src/light_sensor_autorange_averager.sv
// Light sensor auto-ranging averager, top level.
// Depends on lsaa_pkg, lsaa_ram (sample window store) and lsaa_div.
//
// Usage:
//   s_axis carries one conversion per transfer (full and infrared counts);
//   m_axis returns exactly one result per input transfer, in order.
//   The cfg port writes a register whenever cfg_we_i is high; write only
//   while the block is idle. Writing window_seconds clears the window.
// Timing:
//   One item at a time. A saturated sample goes to the output register
//   without the divider or the store; any other sample runs a 12-step
//   divide for the window size, a store read-modify-write and a
//   (24 + clog2(WINDOW_DEPTH+1)) step divide for the average, both on the
//   shared bit-serial divider. s_axis_tready rises with m_axis_tvalid, so
//   an input transfer is taken only after the last result is registered.
// Reset:
//   Window empty, gain 3, integration 5, registers at their defaults. The
//   store needs no clearing pass; only entries written since a clear are read.
// Stall:
//   A result waits in the output register; the next item is taken and
//   processed meanwhile, and waits for that register to free up.
`default_nettype none

module light_sensor_autorange_averager #(
  parameter int WINDOW_DEPTH = 512
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // s_axis_tdata: full_count [15:0], infrared_count [31:16]
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [lsaa_pkg::IN_W-1:0]        s_axis_tdata,
  // m_axis_tdata: visible_count [15:0], saturated [16], gain_index [18:17],
  // integration_index [21:19], night_mode [22], range_changed [23],
  // window_count [33:24], rolling_visible [57:34], corrected_visible [81:58],
  // rejected_count [97:82], zero fill [103:98]
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [lsaa_pkg::OUT_W-1:0]       m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [lsaa_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [lsaa_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  import lsaa_pkg::*;

  localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SW  = 16 + CW;
  localparam int DW  = SW + 8;
  localparam int VW  = (CW > 3) ? CW : 3;
  localparam int SCW = $clog2(DW + 1);
  localparam int NW  = 13;

  // Configuration
  logic [8:0]  ws_q, ws_d;
  logic [23:0] dark_q, dark_d;
  logic [15:0] sat_th_q, sat_th_d;
  logic [15:0] low_th_q, low_th_d;
  logic [3:0]  rcs_q, rcs_d;

  // Sequencer and item
  state_e      state_q, state_d;
  logic [15:0] full_q, full_d;
  logic [15:0] ir_q, ir_d;

  // Window state
  logic [AW-1:0] wp_q, wp_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] size_q, size_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [23:0]   avg_q, avg_d;
  logic [15:0]   rej_q, rej_d;

  // Ranging
  logic [1:0] gain_q, gain_d;
  logic [2:0] integ_q, integ_d;
  logic [3:0] srun_q, srun_d;
  logic [3:0] lrun_q, lrun_d;

  // Output register
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  // Datapath helpers
  logic [15:0]      vis;
  logic             sat, low, sat_in;
  logic             in_fire, out_load;
  logic [3:0]       need;
  logic [WS10_W-1:0] ws10;
  logic [NW-1:0]    q13;
  logic [AW-1:0]    wp_adj;
  logic [CW-1:0]    fill_new;
  logic [CW-1:0]    wp_inc;
  logic             win_full;
  logic [SW-1:0]    sum_new;
  logic [3:0]       srun_n, lrun_n;
  logic [1:0]       gain_n;
  logic [2:0]       integ_n;
  logic             changed;
  logic [15:0]      rej_n;
  logic [23:0]      avg_fin;
  logic [8:0]       ws_wr;

  // Memory and divider control
  logic             mem_re, mem_we;
  logic [15:0]      mem_rdata;
  logic             div_start;
  logic [DW-1:0]    div_dividend;
  logic [VW-1:0]    div_divisor;
  logic [SCW-1:0]   div_steps;
  logic             div_done;
  logic [DW-1:0]    div_quo;

  lsaa_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (vis),
    .re_i    (mem_re),
    .raddr_i (wp_adj),
    .rdata_o (mem_rdata)
  );

  lsaa_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  assign sat_in   = (s_axis_tdata[15:0] >= sat_th_q) || (s_axis_tdata[31:16] >= sat_th_q);

  assign vis  = (full_q >= ir_q) ? (full_q - ir_q) : 16'd0;
  assign sat  = (full_q >= sat_th_q) || (ir_q >= sat_th_q);
  assign low  = (full_q <= low_th_q) && (ir_q <= low_th_q);
  assign need = (rcs_q == 4'd0) ? 4'd1 : rcs_q;
  assign ws10 = (WS10_W'(ws_q) << 3) + (WS10_W'(ws_q) << 1);
  assign q13  = NW'(div_quo[WS10_W-1:0]);

  // Ring adjustments when the window size shrank since the last push
  assign wp_adj   = (CW'(wp_q) >= size_q) ? '0 : wp_q;
  assign win_full = (fill_q == size_q);
  assign fill_new = win_full ? fill_q : fill_q + 1'b1;
  assign wp_inc   = CW'(wp_q) + 1'b1;
  assign sum_new  = sum_q - (win_full ? SW'(mem_rdata) : '0) + SW'(vis);

  assign mem_re = (state_q == ST_ADJ);
  assign mem_we = (state_q == ST_READ);

  // Divider issue: window size at accept, average with the store update
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {ws10, {(DW - WS10_W){1'b0}}};
    div_divisor  = VW'({1'b0, integ_q} + 4'd1);
    div_steps    = SCW'(WS10_W);
    if (state_q == ST_IDLE) begin
      div_start = in_fire && !sat_in;
    end else if (state_q == ST_READ) begin
      div_start    = 1'b1;
      div_dividend = {sum_new, 8'd0};
      div_divisor  = VW'(fill_new);
      div_steps    = SCW'(DW);
    end
  end

  // Run counters and range stepping for the current item
  always_comb begin
    srun_n  = srun_q;
    lrun_n  = lrun_q;
    gain_n  = gain_q;
    integ_n = integ_q;
    changed = 1'b0;
    if (sat) begin
      srun_n = (srun_q < RUN_MAX) ? srun_q + 1'b1 : srun_q;
      lrun_n = '0;
    end else if (low) begin
      lrun_n = (lrun_q < RUN_MAX) ? lrun_q + 1'b1 : lrun_q;
      srun_n = '0;
    end else begin
      srun_n = '0;
      lrun_n = '0;
    end
    if (srun_n >= need) begin
      if (gain_q != 2'd0) begin
        gain_n  = gain_q - 1'b1;
        changed = 1'b1;
      end else if (integ_q != 3'd0) begin
        integ_n = integ_q - 1'b1;
        changed = 1'b1;
      end
      srun_n = '0;
    end else if (lrun_n >= need) begin
      if (integ_q < INTEG_MAX) begin
        integ_n = integ_q + 1'b1;
        changed = 1'b1;
      end else if (gain_q < GAIN_MAX) begin
        gain_n  = gain_q + 1'b1;
        changed = 1'b1;
      end
      lrun_n = '0;
    end
    rej_n   = (sat && rej_q != REJ_MAX) ? rej_q + 1'b1 : rej_q;
    avg_fin = changed ? 24'd0 : avg_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = sat_in ? ST_OUT : ST_WSIZE;
      ST_WSIZE: if (div_done) state_d = ST_ADJ;
      ST_ADJ:   state_d = ST_READ;
      ST_READ:  state_d = ST_AVG;
      ST_AVG:   if (div_done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Register updates
  always_comb begin
    full_d      = full_q;
    ir_d        = ir_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    size_d      = size_q;
    sum_d       = sum_q;
    avg_d       = avg_q;
    rej_d       = rej_q;
    gain_d      = gain_q;
    integ_d     = integ_q;
    srun_d      = srun_q;
    lrun_d      = lrun_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ws_d        = ws_q;
    dark_d      = dark_q;
    sat_th_d    = sat_th_q;
    low_th_d    = low_th_q;
    rcs_d       = rcs_q;
    ws_wr       = cfg_wdata_i[8:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          full_d = s_axis_tdata[15:0];
          ir_d   = s_axis_tdata[31:16];
        end
      end
      ST_WSIZE: begin
        if (div_done) begin
          if (q13 > NW'(WINDOW_DEPTH)) begin
            size_d = CW'(WINDOW_DEPTH);
          end else if (q13 == '0) begin
            size_d = CW'(1);
          end else begin
            size_d = CW'(q13);
          end
        end
      end
      ST_ADJ: begin
        wp_d   = wp_adj;
        fill_d = (fill_q > size_q) ? size_q : fill_q;
      end
      ST_READ: begin
        sum_d  = sum_new;
        fill_d = fill_new;
        wp_d   = (wp_inc == size_q) ? '0 : AW'(wp_inc);
      end
      ST_AVG: begin
        if (div_done) avg_d = div_quo[23:0];
      end
      ST_OUT: begin
        if (out_load) begin
          srun_d  = srun_n;
          lrun_d  = lrun_n;
          gain_d  = gain_n;
          integ_d = integ_n;
          rej_d   = rej_n;
          if (changed) begin
            wp_d   = '0;
            fill_d = '0;
            sum_d  = '0;
            rej_d  = '0;
            avg_d  = '0;
          end
          out_valid_d             = 1'b1;
          out_d.pad               = '0;
          out_d.visible_count     = vis;
          out_d.saturated         = sat;
          out_d.gain_index        = gain_n;
          out_d.integration_index = integ_n;
          out_d.night_mode        = (gain_n == GAIN_MAX) && (integ_n == INTEG_MAX);
          out_d.range_changed     = changed;
          out_d.window_count      = changed ? 10'd0 : 10'(fill_q);
          out_d.rolling_visible   = avg_fin;
          out_d.corrected_visible = (avg_fin > dark_q) ? avg_fin - dark_q : 24'd0;
          out_d.rejected_count    = changed ? 16'd0 : rej_n;
        end
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_WINDOW_SECONDS: begin
          if (ws_wr < WS_MIN) begin
            ws_d = WS_MIN;
          end else if (ws_wr > WS_MAX) begin
            ws_d = WS_MAX;
          end else begin
            ws_d = ws_wr;
          end
          wp_d   = '0;
          fill_d = '0;
          sum_d  = '0;
          rej_d  = '0;
          avg_d  = '0;
        end
        REG_DARK_OFFSET:   dark_d   = cfg_wdata_i;
        REG_SAT_THRESHOLD: sat_th_d = cfg_wdata_i[15:0];
        REG_LOW_THRESHOLD: low_th_d = cfg_wdata_i[15:0];
        REG_RANGE_SAMPLES: rcs_d    = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      size_q      <= CW'(1);
      sum_q       <= '0;
      avg_q       <= '0;
      rej_q       <= '0;
      gain_q      <= GAIN_MAX;
      integ_q     <= INTEG_MAX;
      srun_q      <= '0;
      lrun_q      <= '0;
      out_valid_q <= 1'b0;
      ws_q        <= WS_RESET;
      dark_q      <= '0;
      sat_th_q    <= SAT_RESET;
      low_th_q    <= LOW_RESET;
      rcs_q       <= RCS_RESET;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      size_q      <= size_d;
      sum_q       <= sum_d;
      avg_q       <= avg_d;
      rej_q       <= rej_d;
      gain_q      <= gain_d;
      integ_q     <= integ_d;
      srun_q      <= srun_d;
      lrun_q      <= lrun_d;
      out_valid_q <= out_valid_d;
      ws_q        <= ws_d;
      dark_q      <= dark_d;
      sat_th_q    <= sat_th_d;
      low_th_q    <= low_th_d;
      rcs_q       <= rcs_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    full_q <= full_d;
    ir_q   <= ir_d;
    out_q  <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Window never holds more than the store
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(WINDOW_DEPTH))
    else $error("window fill exceeds store depth");

  // Divider results only arrive while the sequencer waits for them
  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WSIZE || state_q == ST_AVG))
    else $error("divider finished outside a wait state");

  // A range step always reports a cleared window
  a_change_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.range_changed) |->
      (out_q.window_count == 10'd0 && out_q.rolling_visible == 24'd0 &&
       out_q.rejected_count == 16'd0))
    else $error("range step without window clear");

  // A rejected sample without a range step leaves a nonzero reject count
  a_reject_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && out_q.saturated && !out_q.range_changed |->
      out_q.rejected_count != 16'd0)
    else $error("rejected sample not counted");

endmodule

`default_nettype wire

// File: src/lsaa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lsaa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/lsaa_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, variable step count.
// No dependencies.
`default_nettype none

module lsaa_div #(
  parameter int DW = 34,
  parameter int VW = 10,
  localparam int SCW = $clog2(DW + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DW-1:0]  dividend_i,
  input  wire logic [VW-1:0]  divisor_i,
  input  wire logic [SCW-1:0] steps_i,
  output logic                done_o,
  output logic      [DW-1:0]  quotient_o
);

  logic [DW-1:0]  quo_q, quo_d;
  logic [VW-1:0]  rem_q, rem_d;
  logic [VW-1:0]  dvs_q, dvs_d;
  logic [SCW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [VW:0]    shifted;
  logic [VW:0]    diff;
  logic           fits;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], fits};
      rem_d = fits ? diff[VW-1:0] : shifted[VW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == SCW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: dv/light_sensor_autorange_averager_tb.sv
// Self-checking testbench for light_sensor_autorange_averager: directed table, then random
// phases with register changes, random stalls on both streams and one long output hold-off.
// Depends on lsaa_pkg and the RTL of the block only.
module light_sensor_autorange_averager_tb;
  import lsaa_pkg::*;

  localparam int DEPTH           = 512;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES          = 10;
  localparam int PHASE_SAMPLES   = 75;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {SHAPE_NORMAL, SHAPE_SAT, SHAPE_LOW, SHAPE_RAW} shape_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_ADDR_W-1:0]    addr;
    logic [CFG_DATA_W-1:0]    value;
    logic [15:0]              full;
    logic [15:0]              ir;
    logic                     known;
    logic [15:0]              k_vis;
    logic                     k_sat;
    logic [15:0]              k_rej;
  } step_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata;   // full_count [15:0], infrared_count [31:16]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_W-1:0]       m_axis_tdata;   // result_t: visible_count up to rejected_count
  logic                   cfg_we_i;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  light_sensor_autorange_averager #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Register mirror
  logic [8:0]  win_seconds;
  logic [23:0] dark;
  logic [15:0] sat_thr;
  logic [15:0] low_thr;
  logic [3:0]  run_need;

  // Window and ranging state
  logic [15:0] vis_store [0:DEPTH-1];
  logic [8:0]  wr_ptr;
  logic [9:0]  fill;
  logic [24:0] vis_sum;
  logic [1:0]  gain;
  logic [2:0]  integ;
  logic [3:0]  sat_run;
  logic [3:0]  low_run;
  logic [15:0] rej_total;
  logic [23:0] avg_last;

  result_t expected_readings [$];
  step_t   script [$];

  int     err_cnt = 0;
  int     cycle_count = 0;
  int     samples_sent = 0;
  int     results_checked = 0;
  int     range_steps = 0;
  int     rejects_seen = 0;
  int     night_seen = 0;
  int     reg_writes = 0;
  logic [9:0] widest_window = '0;
  bit     tx_steady = 1'b0;
  bit     rx_steady = 1'b0;
  bit     squeeze_req = 1'b0;
  bit     squeeze_done = 1'b0;
  int     burst_left = 0;
  shape_e burst_shape = SHAPE_NORMAL;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int win_len();
    int n;
    n = (int'(win_seconds) * 10) / (int'(integ) + 1);
    if (n > DEPTH) n = DEPTH;
    if (n < 1) n = 1;
    return n;
  endfunction

  task automatic clear_window();
    wr_ptr    = '0;
    fill      = '0;
    vis_sum   = '0;
    rej_total = '0;
    avg_last  = '0;
  endtask

  // Next output word for one conversion; updates the window and ranging state.
  task automatic range_and_average(input logic [15:0] full, input logic [15:0] ir,
                                   output result_t r);
    logic [15:0] vis;
    logic        sat;
    logic        low;
    logic        stepped;
    logic [3:0]  need;
    int          size;
    logic [32:0] quot;
    logic [23:0] corr;
    vis     = (full >= ir) ? full - ir : 16'd0;
    sat     = (full >= sat_thr) || (ir >= sat_thr);
    low     = (full <= low_thr) && (ir <= low_thr);
    need    = (run_need == 4'd0) ? 4'd1 : run_need;
    stepped = 1'b0;

    if (sat) begin
      if (rej_total != REJ_MAX) rej_total++;
    end else begin
      size = win_len();
      if (wr_ptr >= size) wr_ptr = '0;
      if (fill > size) fill = 10'(size);
      if (fill == size) vis_sum = vis_sum - vis_store[wr_ptr];
      vis_store[wr_ptr] = vis;
      vis_sum = vis_sum + vis;
      wr_ptr = (wr_ptr + 1 == size) ? '0 : wr_ptr + 1'b1;
      if (fill < size) fill++;
      quot = {vis_sum, 8'd0} / fill;
      avg_last = quot[23:0];
    end

    if (sat) begin
      if (sat_run != RUN_MAX) sat_run++;
      low_run = '0;
    end else if (low) begin
      if (low_run != RUN_MAX) low_run++;
      sat_run = '0;
    end else begin
      sat_run = '0;
      low_run = '0;
    end

    // bright: gain comes down first; dark: integration goes up first
    if (sat_run >= need) begin
      if (gain != 2'd0) begin
        gain--;
        stepped = 1'b1;
      end else if (integ != 3'd0) begin
        integ--;
        stepped = 1'b1;
      end
      sat_run = '0;
    end else if (low_run >= need) begin
      if (integ < INTEG_MAX) begin
        integ++;
        stepped = 1'b1;
      end else if (gain < GAIN_MAX) begin
        gain++;
        stepped = 1'b1;
      end
      low_run = '0;
    end
    if (stepped) clear_window();

    corr = (avg_last > dark) ? avg_last - dark : 24'd0;
    r = '0;
    r.visible_count     = vis;
    r.saturated         = sat;
    r.gain_index        = gain;
    r.integration_index = integ;
    r.night_mode        = (gain == GAIN_MAX) && (integ == INTEG_MAX);
    r.range_changed     = stepped;
    r.window_count      = fill;
    r.rolling_visible   = avg_last;
    r.corrected_visible = corr;
    r.rejected_count    = rej_total;
  endtask

  // Waits for the block to drain, then writes one register.
  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] value);
    logic [8:0] ws;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    case (addr)
      REG_WINDOW_SECONDS: begin
        ws = value[8:0];
        if (ws < WS_MIN) ws = WS_MIN;
        if (ws > WS_MAX) ws = WS_MAX;
        win_seconds = ws;
        clear_window();
      end
      REG_DARK_OFFSET:   dark     = value[23:0];
      REG_SAT_THRESHOLD: sat_thr  = value[15:0];
      REG_LOW_THRESHOLD: low_thr  = value[15:0];
      REG_RANGE_SAMPLES: run_need = value[3:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [15:0] full, input logic [15:0] ir,
                             input logic known, input logic [15:0] k_vis,
                             input logic k_sat, input logic [15:0] k_rej);
    int      gap;
    result_t r;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ir, full};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    range_and_average(full, ir, r);
    if (known) begin
      r.visible_count  = k_vis;
      r.saturated      = k_sat;
      r.rejected_count = k_rej;
    end
    expected_readings.push_back(r);
    samples_sent++;
  endtask

  // Mostly runs of one kind of conversion, so the run counters actually trip.
  task automatic next_sample(output logic [15:0] full, output logic [15:0] ir);
    int          r;
    logic [15:0] top;
    if (burst_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 14) burst_shape = SHAPE_SAT;
      else if (r < 28) burst_shape = SHAPE_LOW;
      else if (r < 80) burst_shape = SHAPE_NORMAL;
      else burst_shape = SHAPE_RAW;
      burst_left = (burst_shape == SHAPE_SAT || burst_shape == SHAPE_LOW) ?
                   $urandom_range(1, 16) : $urandom_range(1, 8);
    end
    burst_left--;
    top = (sat_thr == 16'd0) ? 16'd0 : sat_thr - 16'd1;
    case (burst_shape)
      SHAPE_SAT: begin
        full = 16'($urandom);
        ir   = 16'($urandom);
        if (sat_thr != 16'd0) begin
          if ($urandom_range(0, 1) == 0) full = 16'($urandom_range(sat_thr, 16'hFFFF));
          else ir = 16'($urandom_range(sat_thr, 16'hFFFF));
        end
      end
      SHAPE_LOW: begin
        full = 16'($urandom_range(0, low_thr));
        ir   = 16'($urandom_range(0, low_thr));
      end
      SHAPE_NORMAL: begin
        full = 16'($urandom_range(0, top));
        if ($urandom_range(0, 2) == 0) ir = 16'($urandom_range(0, top));
        else ir = 16'($urandom_range(0, full >> $urandom_range(0, 8)));
      end
      default: begin
        full = 16'($urandom);
        ir   = 16'($urandom);
      end
    endcase
  endtask

  task automatic shuffle_registers();
    int          r;
    logic [23:0] v;
    r = $urandom_range(0, 99);
    if (r < 35) v = 24'($urandom_range(10, 30));
    else if (r < 45) v = 24'($urandom_range(0, 9));
    else if (r < 55) v = 24'($urandom_range(301, 511));
    else if (r < 62) v = 24'd10;
    else if (r < 69) v = 24'd300;
    else v = 24'($urandom_range(10, 300));
    write_register(REG_WINDOW_SECONDS, v);

    r = $urandom_range(0, 99);
    if (r < 30) v = 24'd0;
    else if (r < 40) v = 24'hFFFFFF;
    else if (r < 70) v = 24'($urandom_range(0, 40000) << 8);
    else v = 24'($urandom);
    write_register(REG_DARK_OFFSET, v);

    r = $urandom_range(0, 99);
    if (r < 8) v = 24'd0;
    else if (r < 15) v = 24'd1;
    else if (r < 30) v = 24'hFFFF;
    else v = 24'($urandom_range(20000, 65535));
    write_register(REG_SAT_THRESHOLD, v);

    r = $urandom_range(0, 99);
    if (r < 15) v = 24'd0;
    else if (r < 23) v = 24'hFFFF;
    else v = 24'($urandom_range(0, 3000));
    write_register(REG_LOW_THRESHOLD, v);

    write_register(REG_RANGE_SAMPLES, 24'($urandom_range(0, 15)));
  endtask

  function automatic step_t smp(input logic [15:0] full, input logic [15:0] ir);
    step_t s;
    s      = '0;
    s.kind = ROW_SAMPLE;
    s.full = full;
    s.ir   = ir;
    return s;
  endfunction

  function automatic step_t smp_known(input logic [15:0] full, input logic [15:0] ir,
                                      input logic [15:0] vis, input logic sat,
                                      input logic [15:0] rej);
    step_t s;
    s       = smp(full, ir);
    s.known = 1'b1;
    s.k_vis = vis;
    s.k_sat = sat;
    s.k_rej = rej;
    return s;
  endfunction

  function automatic step_t reg_row(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [CFG_DATA_W-1:0] value);
    step_t s;
    s       = '0;
    s.kind  = ROW_REG;
    s.addr  = addr;
    s.value = value;
    return s;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_port
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_readings.size() == 0) begin
        $error("result transfer with no conversion pending");
        err_cnt++;
      end else begin
        want = expected_readings.pop_front();
        check_field("visible_count", want.visible_count, got.visible_count);
        check_field("saturated", want.saturated, got.saturated);
        check_field("gain_index", want.gain_index, got.gain_index);
        check_field("integration_index", want.integration_index, got.integration_index);
        check_field("night_mode", want.night_mode, got.night_mode);
        check_field("range_changed", want.range_changed, got.range_changed);
        check_field("window_count", want.window_count, got.window_count);
        check_field("rolling_visible", want.rolling_visible, got.rolling_visible);
        check_field("corrected_visible", want.corrected_visible, got.corrected_visible);
        check_field("rejected_count", want.rejected_count, got.rejected_count);
      end
      results_checked++;
      if (got.range_changed) range_steps++;
      if (got.saturated) rejects_seen++;
      if (got.night_mode) night_seen++;
      if (got.window_count > widest_window) widest_window = got.window_count;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off while the sender keeps pushing
  initial begin : result_sink
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_steady) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    step_t       row;
    int          i;
    int          p;
    int          k;
    logic [15:0] full;
    logic [15:0] ir;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;

    win_seconds = WS_RESET;
    dark        = '0;
    sat_thr     = SAT_RESET;
    low_thr     = LOW_RESET;
    run_need    = RCS_RESET;
    gain        = GAIN_MAX;
    integ       = INTEG_MAX;
    sat_run     = '0;
    low_run     = '0;
    clear_window();

    // Defaults after reset: threshold 60000, low light 750, four samples per step
    script.push_back(smp_known(16'd0, 16'd0, 16'd0, 1'b0, 16'd0));
    script.push_back(smp_known(16'hFFFF, 16'd0, 16'hFFFF, 1'b1, 16'd1));
    script.push_back(smp_known(16'd0, 16'hFFFF, 16'd0, 1'b1, 16'd2));
    script.push_back(smp_known(16'd60000, 16'd59999, 16'd1, 1'b1, 16'd3));
    script.push_back(smp_known(16'd59999, 16'd1, 16'd59998, 1'b0, 16'd3));
    script.push_back(smp(16'd750, 16'd750));
    script.push_back(smp(16'd751, 16'd0));
    script.push_back(reg_row(REG_RANGE_SAMPLES, 24'd0));    // zero run length behaves as one
    script.push_back(smp(16'hFFFF, 16'hFFFF));
    script.push_back(reg_row(REG_WINDOW_SECONDS, 24'd0));   // clamps up to 10 s
    script.push_back(smp(16'd1000, 16'd10));
    script.push_back(reg_row(REG_DARK_OFFSET, 24'hFFFFFF));
    script.push_back(smp(16'd30000, 16'd0));
    script.push_back(reg_row(REG_DARK_OFFSET, 24'h000100));
    script.push_back(smp(16'd30001, 16'd1));
    // zero threshold: all saturated, walk gain then integration to the floor and past it
    script.push_back(reg_row(REG_SAT_THRESHOLD, 24'd0));
    for (i = 0; i < 8; i++) script.push_back(smp(16'd0, 16'd0));
    script.push_back(reg_row(REG_SAT_THRESHOLD, 24'hFFFF));
    script.push_back(reg_row(REG_LOW_THRESHOLD, 24'hFFFF));
    script.push_back(reg_row(REG_WINDOW_SECONDS, 24'h1FF)); // clamps down to 300 s
    // everything low: integration back up first, then gain, then stuck at the top
    for (i = 0; i < 9; i++) script.push_back(smp(16'hFFFE, 16'h0001));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < script.size(); i++) begin
      row = script[i];
      if (row.kind == ROW_REG) write_register(row.addr, row.value);
      else send_sample(row.full, row.ir, row.known, row.k_vis, row.k_sat, row.k_rej);
    end

    for (p = 0; p < PHASES; p++) begin
      tx_steady  = ($urandom_range(0, 3) == 0);
      rx_steady  = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      shuffle_registers();
      if (p == 1) squeeze_req = 1'b1;
      for (k = 0; k < PHASE_SAMPLES; k++) begin
        next_sample(full, ir);
        send_sample(full, ir, 1'b0, 16'd0, 1'b0, 16'd0);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("%0d conversions, %0d results checked: %0d range steps, %0d rejected, %0d night",
             samples_sent, results_checked, range_steps, rejects_seen, night_seen);
    $display("%0d register writes over %0d random phases, widest window %0d samples",
             reg_writes, PHASES, widest_window);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lsaa_pkg.sv
src/lsaa_ram.sv
src/lsaa_div.sv
src/light_sensor_autorange_averager.sv
dv/light_sensor_autorange_averager_tb.sv
